[rtl/pba_pkg.sv]
package pba_pkg;

  // Bitmap geometry
  localparam int MAX_PAGES      = 32768;
  localparam int PAGE_SHIFT     = 12;
  // Reserved area; kept a whole number of bitmap words so the scan starts word-aligned
  localparam int RESERVED_PAGES = 256;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int MEM_WORDS      = MAX_PAGES / WORD_BITS;
  localparam int WADDR_W        = $clog2(MEM_WORDS);
  localparam int PTR_W          = WADDR_W + 1;
  localparam int SCAN_START     = RESERVED_PAGES / WORD_BITS;
  localparam int PAGE_W         = $clog2(MAX_PAGES);
  localparam int CNT_W          = 16;
  localparam int IDX_W          = 32 - PAGE_SHIFT;
  localparam int ALLOC_W        = 27;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RESET = 16'd32768;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic free_rd;
    logic free_chk;
    logic commit;
  } pba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_blocked;
  } pba_sts_t;

endpackage

[rtl/page_bitmap_allocator.sv]
// First-fit page allocator over a used/free bitmap of 32768 pages (512 x 64-bit words).
// Input channel in_*: in_tuser[0] is the opcode (0 allocate, 1 free), in_tdata the
// byte address to free. Result channel out_*: out_tuser is the status (ok, out of
// memory, invalid page), out_tdata carries the allocated address and page counts.
// cfg_wen/cfg_wdata write the page count, which reinitialises the bitmap.
// One item is in work at a time. A free reads its bitmap word, checks it and commits.
// An allocate reads one bitmap word a cycle from page 256 upward through the
// single memory read port, checking each word as it arrives, until it finds a clear
// bit or passes the end; a full bitmap checks all 508 words and one step past the end.
// After reset, and after every page-count write, a clearing pass writes all 512
// words, one a cycle, while in_tready stays low; configuration writes are still
// taken and restart the pass. The result sits in an output register; while the
// receiver stalls, the next item is still taken and worked on, but its result
// waits and in_tready stays low until that register is taken.
module page_bitmap_allocator
  import pba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,     // page_count
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] page_address
  input  logic [0:0]  in_tuser,      // [0] opcode
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // [26:0] alloc_address, [42:27] used_pages,
                                     // [58:43] free_pages, [63:59] zero
  output logic [1:0]  out_tuser      // [1:0] status
);

  pba_cmd_t           cmd;
  pba_sts_t           sts;
  logic [ALLOC_W-1:0] alloc_address;
  status_t            status;
  logic [CNT_W-1:0]   used_pages;
  logic [CNT_W-1:0]   free_pages;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .in_page_address   (in_tdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_tready        (out_tready),
    .out_valid         (out_tvalid),
    .out_alloc_address (alloc_address),
    .out_status        (status),
    .out_used_pages    (used_pages),
    .out_free_pages    (free_pages)
  );

  // Result packing
  assign out_tdata = {5'd0, free_pages, used_pages, alloc_address};
  assign out_tuser = status;

  // Used plus free never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (({1'b0, used_pages} + {1'b0, free_pages}) <= (CNT_W+1)'(MAX_PAGES)))
    else $error("used plus free pages exceed capacity");

  // A failed allocation returns no address
  a_oom_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status == STATUS_OOM)) |-> (alloc_address == '0))
    else $error("address returned with out-of-memory status");

  // One item at a time: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while an item is in work");

  // A page-count write starts the clearing pass
  a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |=> !in_tready)
    else $error("request taken during the clearing pass");

endmodule

[rtl/pba_datapath.sv]
module pba_datapath
  import pba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CNT_W-1:0]     cfg_wdata,
  input  logic [31:0]          in_page_address,
  input  pba_cmd_t             cmd,
  output pba_sts_t             sts,
  input  logic                 out_tready,
  output logic                 out_valid,
  output logic [ALLOC_W-1:0]   out_alloc_address,
  output status_t              out_status,
  output logic [CNT_W-1:0]     out_used_pages,
  output logic [CNT_W-1:0]     out_free_pages
);

  localparam logic [CNT_W:0] MAX_EXT = (CNT_W+1)'(MAX_PAGES);
  localparam logic [CNT_W-1:0] RES_CNT = CNT_W'(RESERVED_PAGES);

  // Page count clamped to capacity
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] pc);
    if ({1'b0, pc} > MAX_EXT) begin
      return MAX_EXT[CNT_W-1:0];
    end
    return pc;
  endfunction

  // Used count straight after a reinitialisation
  function automatic logic [CNT_W-1:0] used_init(input logic [CNT_W-1:0] pc);
    logic [CNT_W-1:0] e;
    e = clamp_count(pc);
    return (e < RES_CNT) ? e : RES_CNT;
  endfunction

  // Index of the lowest clear bit
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

  logic [WORD_BITS-1:0]  mem [MEM_WORDS];
  logic [WORD_BITS-1:0]  q_r;

  logic [CNT_W-1:0]      page_count_r;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [WADDR_W-1:0]    clr_ptr_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      chk_ptr_r;
  logic                  chk_v_r;
  logic [IDX_W-1:0]      idx_r;
  logic [ALLOC_W-1:0]    res_addr_r, res_addr_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r;
  logic [ALLOC_W-1:0]    out_addr_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_used_r;
  logic [CNT_W-1:0]      out_free_r;

  logic [CNT_W-1:0]      eff_cnt;
  logic [CNT_W:0]        end_sum;
  logic [PTR_W-1:0]      end_word;
  logic                  word_full;
  logic [BIT_W-1:0]      zb;
  logic [PAGE_W-1:0]     cand_page;
  logic                  past_end;
  logic                  scan_done;
  logic                  scan_hit;
  logic                  free_ok;
  logic                  bit_set;
  logic                  free_hit;
  logic [WADDR_W-1:0]    rd_addr;
  logic                  we;
  logic [WADDR_W-1:0]    wa;
  logic [WORD_BITS-1:0]  wd;
  logic [WORD_BITS-1:0]  clr_word;

  // Limits
  assign eff_cnt  = clamp_count(page_count_r);
  assign end_sum  = {1'b0, eff_cnt} + (CNT_W+1)'(WORD_BITS - 1);
  assign end_word = PTR_W'(end_sum >> BIT_W);

  // Scan check on the word read last cycle
  assign word_full = &q_r;
  assign zb        = lowest_zero(q_r);
  assign cand_page = {chk_ptr_r[WADDR_W-1:0], zb};
  assign past_end  = (chk_ptr_r >= end_word);
  assign scan_done = cmd.scan && chk_v_r && (past_end || !word_full);
  assign scan_hit  = scan_done && !past_end && ({1'b0, cand_page} < eff_cnt);

  // Free check
  assign free_ok  = (idx_r < IDX_W'(eff_cnt));
  assign bit_set  = q_r[idx_r[BIT_W-1:0]];
  assign free_hit = cmd.free_chk && free_ok && bit_set;

  // Word written during the clearing pass
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      clr_word[b] = ({clr_ptr_r, BIT_W'(b)} < PAGE_W'(RESERVED_PAGES));
    end
  end

  // Memory port selection
  assign rd_addr = cmd.free_rd ? idx_r[BIT_W +: WADDR_W] : ptr_r[WADDR_W-1:0];

  always_comb begin
    we = 1'b0;
    wa = clr_ptr_r;
    wd = clr_word;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (scan_hit) begin
      we = 1'b1;
      wa = chk_ptr_r[WADDR_W-1:0];
      wd = q_r | (WORD_BITS'(1) << zb);
    end else if (free_hit) begin
      we = 1'b1;
      wa = idx_r[BIT_W +: WADDR_W];
      wd = q_r & ~(WORD_BITS'(1) << idx_r[BIT_W-1:0]);
    end
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= mem[rd_addr];
  end

  // Result of the current item
  always_comb begin
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    if (scan_done) begin
      res_addr_nxt   = scan_hit ? ALLOC_W'({cand_page, PAGE_SHIFT'(0)}) : '0;
      res_status_nxt = scan_hit ? STATUS_OK : STATUS_OOM;
    end else if (cmd.free_chk) begin
      res_addr_nxt   = '0;
      res_status_nxt = free_ok ? STATUS_OK : STATUS_INVALID;
    end
  end

  // Running used-page count
  always_comb begin
    used_nxt = used_r;
    if (cfg_wen) begin
      used_nxt = used_init(cfg_wdata);
    end else if (scan_hit) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (free_hit) begin
      used_nxt = used_r - CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_COUNT_RESET;
      used_r       <= used_init(PAGE_COUNT_RESET);
      clr_ptr_r    <= '0;
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cfg_wen) begin
        page_count_r <= cfg_wdata;
        clr_ptr_r    <= '0;
      end else if (cmd.clear) begin
        clr_ptr_r <= clr_ptr_r + WADDR_W'(1);
      end
      if (cmd.load) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_v_r <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load) begin
      idx_r <= in_page_address[31:PAGE_SHIFT];
      ptr_r <= PTR_W'(SCAN_START);
    end else if (cmd.scan) begin
      ptr_r     <= ptr_r + PTR_W'(1);
      chk_ptr_r <= ptr_r;
    end
    if (cmd.commit) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_used_r   <= used_r;
      out_free_r   <= eff_cnt - used_r;
    end
  end

  assign sts.clear_last  = (clr_ptr_r == WADDR_W'(MEM_WORDS - 1));
  assign sts.scan_done   = scan_done;
  assign sts.out_blocked = out_valid_r && !out_tready;

  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_used_pages    = out_used_r;
  assign out_free_pages    = out_free_r;

endmodule

[rtl/pba_ctrl.sv]
module pba_ctrl
  import pba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wen,
  input  logic     in_tvalid,
  input  logic     in_opcode,
  output logic     in_tready,
  input  pba_sts_t sts,
  output pba_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = !cfg_wen;
        if (in_tvalid && !cfg_wen) begin
          cmd.load  = 1'b1;
          state_nxt = in_opcode ? S_FREE_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // A page-count write always restarts the clearing pass
    if (cfg_wen) begin
      state_nxt = S_CLEAR;
    end
  end

endmodule

[dv/tb_page_bitmap_allocator.sv]
`timescale 1ns / 100ps

module tb_page_bitmap_allocator;
  import pba_pkg::*;

  // Request opcodes as carried on in_tuser[0]
  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE  = 1'b1;

  localparam int ITEMS_PER_PHASE = 120;
  localparam int N_PHASES        = 13;
  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic [ALLOC_W-1:0] alloc_address;
    status_t            status;
    logic [CNT_W-1:0]   used_pages;
    logic [CNT_W-1:0]   free_pages;
  } page_result_t;

  // Page bitmap mirror: predicts each result and queues it for the checker
  class page_book;
    bit           page_used[MAX_PAGES];
    int unsigned  page_limit;
    int unsigned  used_count;
    int unsigned  live_pages[$];
    page_result_t pending_results[$];
    int           errors;
    int           results_seen;
    int           n_alloc, n_free, n_oom, n_invalid;

    function new();
      set_page_count(PAGE_COUNT_RESET);
    endfunction

    // Page-count write: counts above capacity saturate, bitmap back to reserved-only
    function void set_page_count(logic [CNT_W-1:0] value);
      page_limit = (value > MAX_PAGES) ? MAX_PAGES : value;
      foreach (page_used[i]) page_used[i] = (i < RESERVED_PAGES);
      used_count = (page_limit < RESERVED_PAGES) ? page_limit : RESERVED_PAGES;
      live_pages.delete();
    endfunction

    function bit pick_live_page(output int unsigned idx);
      if (live_pages.size() == 0) return 0;
      idx = live_pages[$urandom_range(0, live_pages.size() - 1)];
      return 1;
    endfunction

    // Accepted request: apply to the mirror and queue the expected result
    function void log_request(bit op, logic [31:0] addr);
      page_result_t res;
      int unsigned  idx;
      int           pos[$];
      res.alloc_address = '0;
      res.status        = STATUS_OK;
      if (op == OP_ALLOC) begin
        n_alloc++;
        res.status = STATUS_OOM;
        for (idx = RESERVED_PAGES; idx < page_limit; idx++) begin
          if (!page_used[idx]) begin
            page_used[idx] = 1'b1;
            used_count++;
            live_pages.push_back(idx);
            res.alloc_address = ALLOC_W'(idx << PAGE_SHIFT);
            res.status        = STATUS_OK;
            break;
          end
        end
        if (res.status == STATUS_OOM) n_oom++;
      end else begin
        n_free++;
        idx = addr >> PAGE_SHIFT;
        if (idx >= page_limit) begin
          res.status = STATUS_INVALID;
          n_invalid++;
        end else if (page_used[idx]) begin
          page_used[idx] = 1'b0;
          used_count--;
          pos = live_pages.find_first_index(p) with (p == idx);
          if (pos.size() != 0) live_pages.delete(pos[0]);
        end
      end
      res.used_pages = CNT_W'(used_count);
      res.free_pages = CNT_W'(page_limit - used_count);
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [63:0] data, logic [1:0] user);
      page_result_t res;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding: tdata 0x%0h tuser %0d", data, user);
        errors++;
        return;
      end
      res = pending_results.pop_front();
      compare_field("alloc_address", res.alloc_address, data[26:0]);
      compare_field("used_pages",    res.used_pages,    data[42:27]);
      compare_field("free_pages",    res.free_pages,    data[58:43]);
      compare_field("padding",       '0,                data[63:59]);
      compare_field("status",        res.status,        user);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wen;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] page_address
  logic [0:0]  in_tuser;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [26:0] alloc_address, [42:27] used_pages, [58:43] free_pages
  logic [1:0]  out_tuser;  // [1:0] status

  page_book ledger = new();
  int       cycle_count = 0;

  page_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               ledger.pending());
      $display("tb_page_bitmap_allocator failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tdata, out_tuser);
  end

  // Receiver: stretches of steady, patchy or sparse ready, one long hold-off
  initial begin
    int  stretch;
    int  mode;
    bit  held;
    held       = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && ledger.results_seen >= 300) begin
        held = 1'b1;
        @(negedge clk);
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(8, 64);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 1) == 1);
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until taken
  task automatic send_request(bit op, logic [31:0] addr);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = addr;
    do @(posedge clk); while (!in_tready);
    ledger.log_request(op, addr);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata  = $urandom();
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and wait for the block to drain
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_page_count(logic [15:0] value);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    ledger.set_page_count(value);
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // Mostly allocations and frees of live pages, some stray and out-of-range frees
  task automatic make_request(output bit op, output logic [31:0] addr);
    int          pick;
    int unsigned idx;
    logic [11:0] offset;
    pick   = $urandom_range(0, 99);
    offset = 12'($urandom_range(0, 4095));
    op     = OP_FREE;
    addr   = $urandom();
    if (pick < 50) begin
      op = OP_ALLOC;
    end else if (pick < 76) begin
      if (ledger.pick_live_page(idx)) addr = (idx << PAGE_SHIFT) | offset;
      else op = OP_ALLOC;
    end else if (pick < 90) begin
      idx  = $urandom_range(0, ledger.page_limit + 15);
      addr = (idx << PAGE_SHIFT) | offset;
    end
  endtask

  initial begin
    logic [15:0] phase_counts[N_PHASES];
    bit          op;
    logic [31:0] addr;
    int          burst_left;
    bit          steady;
    phase_counts = '{16'd0, 16'd100, 16'd256, 16'd257, 16'd260, 16'd320, 16'd65535,
                     16'd1000, 16'd33000, 16'd512, 16'd0, 16'd0, 16'd32768};
    phase_counts[10] = 16'($urandom_range(256, 2048));
    phase_counts[11] = 16'($urandom_range(256, 600));
    rst_n      = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset page count, first-fit reuse, reserved and boundary frees
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, 32'hFFFF_FFFF);   // address ignored on allocate
    send_request(OP_FREE,  32'h0010_0FFF);   // page 256, offset bits set
    send_request(OP_ALLOC, 32'h0000_0000);   // lowest free is 256 again
    send_request(OP_FREE,  32'h0010_0000);
    send_request(OP_FREE,  32'h0010_0000);   // already free
    send_request(OP_FREE,  32'h0000_0000);   // reserved page 0
    send_request(OP_FREE,  32'h000F_FFFF);   // reserved page 255
    send_request(OP_ALLOC, 32'h5555_5555);   // freed reserved pages are not reused
    send_request(OP_FREE,  32'h07FF_FFFF);   // last page, already free
    send_request(OP_FREE,  32'h0800_0000);   // first page past the count
    send_request(OP_FREE,  32'hFFFF_FFFF);
    send_request(OP_FREE,  32'hAAAA_AAAA);
    send_request(OP_ALLOC, 32'hAAAA_AAAA);

    for (int p = -1; p < N_PHASES; p++) begin
      if (p >= 0) begin
        drain();
        write_page_count(phase_counts[p]);
        // edges of the managed range
        send_request(OP_ALLOC, $urandom());
        send_request(OP_FREE, ledger.page_limit << PAGE_SHIFT);
        if (ledger.page_limit > 0)
          send_request(OP_FREE, ((ledger.page_limit - 1) << PAGE_SHIFT) | 12'hFFF);
      end
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (!steady && $urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 10));
        end
        burst_left--;
        make_request(op, addr);
        send_request(op, addr);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d requests (%0d allocate, %0d free) across %0d page-count settings",
             ledger.n_alloc + ledger.n_free, ledger.n_alloc, ledger.n_free, N_PHASES + 1);
    $display("%0d results checked: %0d out of memory, %0d invalid frees, %0d mismatches",
             ledger.results_seen, ledger.n_oom, ledger.n_invalid, ledger.errors);
    if (ledger.errors == 0) begin
      $display("tb_page_bitmap_allocator passed");
    end else begin
      $display("tb_page_bitmap_allocator failed");
    end
    $finish;
  end

endmodule
